@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/tfs_pkg.sv @@
// types, constants and crc step function for the telemetry frame serializer
package tfs_pkg;

  localparam int unsigned FRAME_BYTES = 30;
  localparam int unsigned CRC_SPAN    = 28;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned BODY_W      = 8 * CRC_SPAN;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CRC_LO_POS = POS_W'(CRC_SPAN);

  typedef struct packed {
    logic [31:0] timestamp;
    logic [7:0]  phase_code;
    logic        sensor_valid;
    logic        nav_valid;
    logic [31:0] altitude_bits;
    logic [31:0] velocity_bits;
    logic [31:0] temperature_bits;
    logic [31:0] pressure_bits;
    logic [31:0] battery_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [POS_W-1:0] byte_position;
    logic             last_byte;
  } out_item_t;

  typedef struct packed {
    logic init;
    logic en;
  } crc_ctl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/tfs_crc16.sv @@
// byte-wide crc-16/ccitt-false accumulator
module tfs_crc16 (
  input  logic              clk,
  input  tfs_pkg::crc_ctl_t ctl,
  input  logic [7:0]        data,
  output logic [15:0]       crc
);
  import tfs_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    priority if (ctl.init) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.en) begin
      crc_nxt = crc16_byte(crc_r, data);
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

@@ hw/rtl/telemetry_frame_serializer_crc16_unit.sv @@
// telemetry frame serializer top level: 30-byte frame per update with crc-16 trailer
//
// Each accepted update is emitted as a 30-byte little-endian frame, one byte per
// transaction on the out_ channel: sync word, packet counter, flight state,
// timestamp, five raw float patterns (zeroed by the valid flags) and a
// CRC-16/CCITT-FALSE over bytes 0 to 27, low byte first. The frame body is held
// in a byte-wide shift register and the CRC is updated one byte per cycle as the
// bytes leave, when the output is not stalled; the next update is accepted in the
// cycle the last byte moves into the output register. Output stalls hold the
// frame back. The packet counter advances on every accepted update and wraps at
// 256. sync_word must be written through cfg_we/cfg_data only while idle; the
// block itself does not enforce this.
module telemetry_frame_serializer_crc16_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tfs_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tfs_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data
);
  import tfs_pkg::*;

  `include "assert_macros.svh"

  logic [15:0]       sync_r;
  logic [7:0]        count_r;
  logic              busy_r;
  logic              busy_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [BODY_W-1:0] body_r;
  logic [BODY_W-1:0] body_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;
  logic              advance;
  logic              accept;
  logic              last_issue;
  logic [7:0]        cur_byte;
  logic [15:0]       crc;
  crc_ctl_t          crc_ctl;
  logic [31:0]       alt;
  logic [31:0]       vel;
  logic [31:0]       tmp;
  logic [31:0]       prs;
  logic [31:0]       bat;

  assign advance    = busy_r && (!out_valid_r || out_ready);
  assign last_issue = advance && (pos_r == LAST_POS);
  assign in_ready   = !busy_r || last_issue;
  assign accept     = in_valid && in_ready;

  assign alt = in_data.sensor_valid ? in_data.altitude_bits : 32'h0;
  assign vel = in_data.nav_valid ? in_data.velocity_bits : 32'h0;
  assign tmp = in_data.sensor_valid ? in_data.temperature_bits : 32'h0;
  assign prs = in_data.sensor_valid ? in_data.pressure_bits : 32'h0;
  assign bat = in_data.sensor_valid ? in_data.battery_bits : 32'h0;

  always_comb begin
    priority if (pos_r < CRC_LO_POS) begin
      cur_byte = body_r[7:0];
    end else if (pos_r == CRC_LO_POS) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  always_comb begin
    priority if (accept) begin
      body_nxt = {bat, prs, tmp, vel, alt, in_data.timestamp, in_data.phase_code,
                  count_r, sync_r};
    end else if (advance) begin
      body_nxt = {8'h00, body_r[BODY_W-1:8]};
    end else begin
      body_nxt = body_r;
    end
  end

  always_comb begin
    priority if (accept) begin
      busy_nxt = 1'b1;
    end else if (last_issue) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
  end

  assign out_data_nxt.out_byte      = cur_byte;
  assign out_data_nxt.byte_position = pos_r;
  assign out_data_nxt.last_byte     = (pos_r == LAST_POS);

  assign crc_ctl.init = accept;
  assign crc_ctl.en   = advance && (pos_r < CRC_LO_POS);

  tfs_crc16 u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (body_r[7:0]),
    .crc  (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= 16'h0000;
      count_r     <= 8'h00;
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_data;
      end
      if (accept) begin
        count_r <= count_r + 8'd1;
      end
      busy_r <= busy_nxt;
      if (accept) begin
        pos_r <= '0;
      end else if (advance) begin
        pos_r <= pos_r + POS_W'(1);
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    body_r <= body_nxt;
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_last_pos, out_valid && out_data.last_byte |-> out_data.byte_position == LAST_POS, "last byte flag off the final position")
  `ASSERT_CLK(a_accept_start, accept |=> busy_r && pos_r == '0, "frame did not restart after accept")
  `ASSERT_CLK(a_accept_idle, accept |-> !busy_r || pos_r == LAST_POS, "update accepted mid-frame")
  `ASSERT_CLK(a_pos_range, busy_r |-> pos_r <= LAST_POS, "byte position past frame end")

endmodule
